FILE: src/irkt_pkg.sv
// Package with the shared types, register codes and key table of the IR key tracker.
package irkt_pkg;

   localparam int KEY_COUNT_DEF      = 45;
   localparam int HALF_BIT_LIMIT_DEF = 128;
   localparam int ROM_ENTRIES        = 45;
   localparam int TASK_DEPTH         = 2;
   localparam int RSP_DEPTH          = 4;

   localparam logic [63:0] REPEAT_CODE = 64'd4;

   localparam logic [1:0] CSR_IDLE_GAP = 2'd0;
   localparam logic [1:0] CSR_RELEASE  = 2'd1;
   localparam logic [1:0] CSR_PREAMBLE = 2'd2;
   localparam logic [1:0] CSR_END_GAP  = 2'd3;

   localparam logic [15:0] IDLE_GAP_RST = 16'd2000;
   localparam logic [15:0] RELEASE_RST  = 16'd4000;
   localparam logic [12:0] PREAMBLE_RST = 13'd16;
   localparam logic [12:0] END_GAP_RST  = 13'd20;

   localparam logic       KIND_DOWN = 1'b0;
   localparam logic       KIND_UP   = 1'b1;
   localparam logic       CMD_EDGE  = 1'b0;

   typedef struct packed {
      logic        command;
      logic [15:0] event_time;
      logic        edge_level;
   } req_type;

   typedef struct packed {
      logic        event_kind;
      logic        key_known;
      logic [5:0]  key_index;
      logic [63:0] raw_code;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic        resolve;
      logic [63:0] code;
      logic [15:0] event_time;
   } task_type;

   typedef struct packed {
      logic [15:0] idle_gap_ticks;
      logic [15:0] release_ticks;
      logic [12:0] preamble_units;
      logic [12:0] end_gap_units;
   } cfg_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_CHECK,
      ST_EMIT
   } back_state_type;

   localparam logic [63:0] KEY_ROM [ROM_ENTRIES] = '{
      64'h0adb76db5577f0, 64'h0aed75bb5577f0, 64'h0d575f5b5577f0,
      64'h15555ff6aab7f0, 64'h15557fd6aab7f0, 64'h1555bfb6aab7f0,
      64'h1555ff56aab7f0, 64'h1556bf76aab7f0, 64'h1556fed6aab7f0,
      64'h15577eb6aab7f0, 64'h1557fd56aab7f0, 64'h155abef6aab7f0,
      64'h155afdd6aab7f0, 64'h155bfb56aab7f0, 64'h156abdf6aab7f0,
      64'h156b7bb6aab7f0, 64'h156d7b76aab7f0, 64'h156ef6b6aab7f0,
      64'h156fed56aab7f0, 64'h1575f5d6aab7f0, 64'h1576f5b6aab7f0,
      64'h1577eb56aab7f0, 64'h157bead6aab7f0, 64'h157deab6aab7f0,
      64'h157fd556aab7f0, 64'h15aaf7d6aab7f0, 64'h15d6ebb6aab7f0,
      64'h16aab7f6aab7f0, 64'h16ab6fb6aab7f0, 64'h16abdf56aab7f0,
      64'h16added6aab7f0, 64'h16b56ef6aab7f0, 64'h16b5ddd6aab7f0,
      64'h16b6ddb6aab7f0, 64'h16b7bb56aab7f0, 64'h16ef6b56aab7f0,
      64'h175ad776aab7f0, 64'h176ad6f6aab7f0, 64'h176f5b56aab7f0,
      64'h1775ad76aab7f0, 64'h177eb556aab7f0, 64'h17db55b6aab7f0,
      64'h1d7abab6aab7f0, 64'h1d7d7556aab7f0, 64'h1dad5bb6aab7f0
   };

endpackage

FILE: src/irkt_fifo.sv
// Small synchronous queue used between the front, the back and the result port.
module irkt_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             full,
   output logic             empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= wdata;
      end
   end

endmodule

FILE: src/irkt_front.sv
// Front part: measures edge intervals, assembles the code and posts a task for each accepted item.
module irkt_front import irkt_pkg::*; #(
   parameter int HALF_BIT_LIMIT = HALF_BIT_LIMIT_DEF
) (
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   input  logic     accept,
   input  req_type  req,
   output task_type task_out
);

   logic        in_burst_ff, in_burst_in;
   logic        frame_open_ff, frame_open_in;
   logic [15:0] prev_edge_ff, prev_edge_in;
   logic [15:0] burst_time_ff, burst_time_in;
   logic [7:0]  hbi_ff, hbi_in;
   logic [63:0] accum_ff, accum_in;
   logic [63:0] prev_code_ff, prev_code_in;

   logic [15:0] diff, idle_diff;
   logic [16:0] rounded;
   logic [12:0] len;
   logic [13:0] stop_sum;
   logic [7:0]  stop, stop_m1;
   logic [5:0]  lo, hi;
   logic [63:0] mask;
   logic        do_resolve;

   always_comb begin
      diff      = req.event_time - prev_edge_ff;
      idle_diff = req.event_time - burst_time_ff;
      rounded   = {1'b0, diff} + 17'd8;
      len       = rounded[16:4];
      stop_sum  = 14'(hbi_ff) + 14'(len);
      stop      = (stop_sum > 14'(HALF_BIT_LIMIT)) ? 8'(HALF_BIT_LIMIT) : stop_sum[7:0];
      stop_m1   = stop - 8'd1;
      lo        = hbi_ff[6:1];
      hi        = stop_m1[6:1];
      mask      = ({64{1'b1}} << lo) & ({64{1'b1}} >> (6'd63 - hi));

      in_burst_in   = in_burst_ff;
      frame_open_in = frame_open_ff;
      prev_edge_in  = prev_edge_ff;
      burst_time_in = burst_time_ff;
      hbi_in        = hbi_ff;
      accum_in      = accum_ff;
      do_resolve    = 1'b0;

      if (req.command == CMD_EDGE) begin
         if (!in_burst_ff && !req.edge_level) begin
            in_burst_in = 1'b1;
         end else if (len > cfg.end_gap_units && !req.edge_level) begin
            frame_open_in = 1'b0;
            do_resolve    = 1'b1;
         end else if (len == cfg.preamble_units && req.edge_level) begin
            hbi_in        = '0;
            frame_open_in = 1'b1;
            accum_in      = '0;
         end else if (frame_open_ff && hbi_ff < 8'(HALF_BIT_LIMIT) && len != '0) begin
            // Fill the half-bit range in one step; two half-bits share a code bit.
            if (req.edge_level) begin
               accum_in = accum_ff | mask;
            end
            hbi_in = stop;
         end
         prev_edge_in  = req.event_time;
         burst_time_in = req.event_time;
      end else if (in_burst_ff && idle_diff > cfg.idle_gap_ticks) begin
         in_burst_in   = 1'b0;
         frame_open_in = 1'b0;
         do_resolve    = 1'b1;
      end

      prev_code_in        = prev_code_ff;
      task_out.resolve    = do_resolve;
      task_out.event_time = req.event_time;
      task_out.code       = accum_ff;
      if (accum_ff == REPEAT_CODE) begin
         task_out.code = prev_code_ff;
      end else if (do_resolve) begin
         prev_code_in = accum_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_burst_ff   <= 1'b0;
         frame_open_ff <= 1'b0;
         prev_edge_ff  <= '0;
         burst_time_ff <= '0;
         hbi_ff        <= 8'd64;
         accum_ff      <= '0;
         prev_code_ff  <= '0;
      end else if (accept) begin
         in_burst_ff   <= in_burst_in;
         frame_open_ff <= frame_open_in;
         prev_edge_ff  <= prev_edge_in;
         burst_time_ff <= burst_time_in;
         hbi_ff        <= hbi_in;
         accum_ff      <= accum_in;
         prev_code_ff  <= prev_code_in;
      end
   end

endmodule

FILE: src/irkt_back.sv
// Back part: looks up the key, tracks the held key and emits key events.
module irkt_back import irkt_pkg::*; #(
   parameter int KEY_COUNT = KEY_COUNT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic [15:0] release_ticks,
   input  task_type    task_in,
   input  logic        task_empty,
   output logic        task_pop,
   input  logic        out_full,
   output logic        out_push,
   output rsp_type     out_item
);

   back_state_type state_ff, state_in;
   task_type    task_ff;
   logic        known_ff, known_in;
   logic [5:0]  idx_ff, idx_in;
   logic        up_ff, up_in, down_ff, down_in;
   logic [5:0]  up_idx_ff, up_idx_in;
   logic        held_valid_ff, held_valid_in;
   logic [5:0]  held_index_ff, held_index_in;
   logic [15:0] press_time_ff, press_time_in;
   logic [15:0] since_press;
   logic        change;

   always_comb begin
      known_in = 1'b0;
      idx_in   = '0;
      for (int i = ROM_ENTRIES - 1; i >= 0; i--) begin
         if (i < KEY_COUNT && KEY_ROM[i] == task_ff.code) begin
            known_in = 1'b1;
            idx_in   = 6'(i);
         end
      end
   end

   always_comb begin
      state_in      = state_ff;
      up_in         = up_ff;
      down_in       = down_ff;
      up_idx_in     = up_idx_ff;
      held_valid_in = held_valid_ff;
      held_index_in = held_index_ff;
      press_time_in = press_time_ff;
      task_pop      = 1'b0;
      out_push      = 1'b0;
      since_press   = task_ff.event_time - press_time_ff;
      change        = !(held_valid_ff == known_ff && (!known_ff || held_index_ff == idx_ff));
      out_item.event_kind = KIND_UP;
      out_item.key_known  = 1'b1;
      out_item.key_index  = up_idx_ff;
      out_item.raw_code   = '0;
      out_item.last       = !down_ff;

      case (state_ff)
         ST_IDLE: begin
            if (!task_empty) begin
               task_pop = 1'b1;
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            up_idx_in = held_index_ff;
            if (task_ff.resolve) begin
               up_in   = change && held_valid_ff;
               down_in = change;
               if (change) begin
                  held_valid_in = known_ff;
                  held_index_in = known_ff ? idx_ff : '0;
               end
               press_time_in = task_ff.event_time;
            end else begin
               up_in   = held_valid_ff && since_press > release_ticks;
               down_in = 1'b0;
               if (up_in) begin
                  held_valid_in = 1'b0;
                  held_index_in = '0;
               end
            end
            state_in = (up_in || down_in) ? ST_EMIT : ST_IDLE;
         end
         ST_EMIT: begin
            if (!up_ff) begin
               out_item.event_kind = KIND_DOWN;
               out_item.key_known  = known_ff;
               out_item.key_index  = idx_ff;
               out_item.raw_code   = task_ff.code;
               out_item.last       = 1'b1;
            end
            if (!out_full) begin
               out_push = 1'b1;
               if (up_ff) begin
                  up_in    = 1'b0;
                  state_in = down_ff ? ST_EMIT : ST_IDLE;
               end else begin
                  down_in  = 1'b0;
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         up_ff         <= 1'b0;
         down_ff       <= 1'b0;
         held_valid_ff <= 1'b0;
         held_index_ff <= '0;
         press_time_ff <= '0;
      end else begin
         state_ff      <= state_in;
         up_ff         <= up_in;
         down_ff       <= down_in;
         held_valid_ff <= held_valid_in;
         held_index_ff <= held_index_in;
         press_time_ff <= press_time_in;
      end
   end

   always_ff @(posedge clock) begin
      up_idx_ff <= up_idx_in;
      if (task_pop) begin
         task_ff <= task_in;
      end
      if (state_ff == ST_LOOKUP) begin
         known_ff <= known_in;
         idx_ff   <= idx_in;
      end
   end

   a_idle_nothing_pending: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !(up_ff || down_ff))
      else $error("events pending while back part is idle");

   a_push_only_in_emit: assert property (@(posedge clock) disable iff (reset)
      out_push |-> (state_ff == ST_EMIT))
      else $error("result pushed outside the emit step");

   a_press_time_taken: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHECK && task_ff.resolve) |=>
         (press_time_ff == $past(task_ff.event_time)))
      else $error("press time not updated on resolve");

   a_lookup_after_pop: assert property (@(posedge clock) disable iff (reset)
      task_pop |=> (state_ff == ST_LOOKUP))
      else $error("task popped without lookup");

endmodule

FILE: src/ir_pulse_decoder_key_tracker_top.sv
// Top level of the IR pulse-length decoder and key tracker.
// An accepted item is written to the task queue; the back part pops it, takes a
// lookup step and a check step, and emits any events in an emit step that waits
// while the result queue is full. The back part's sequencer takes one task at a
// time and pops the next only once it is idle again. Reset is synchronous and active high; it
// restores register defaults and clears the decoder state and both queues.
module ir_pulse_decoder_key_tracker_top import irkt_pkg::*; #(
   parameter int KEY_COUNT      = KEY_COUNT_DEF,
   parameter int HALF_BIT_LIMIT = HALF_BIT_LIMIT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // Input items.
   input  logic        req_push,
   output logic        req_full,
   input  req_type     req_data,
   // Result items.
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output rsp_type     rsp_data,
   // Configuration writes.
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   cfg_type  cfg_ff;
   task_type front_task, back_task;
   logic     req_accept, task_empty, task_pop;
   logic     out_full, out_push;
   rsp_type  out_item;
   logic [$bits(task_type)-1:0] back_task_bits;
   logic [$bits(rsp_type)-1:0]  rsp_bits;

   // Configuration writes are always taken.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.idle_gap_ticks <= IDLE_GAP_RST;
         cfg_ff.release_ticks  <= RELEASE_RST;
         cfg_ff.preamble_units <= PREAMBLE_RST;
         cfg_ff.end_gap_units  <= END_GAP_RST;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_IDLE_GAP: cfg_ff.idle_gap_ticks <= csr_data;
            CSR_RELEASE:  cfg_ff.release_ticks  <= csr_data;
            CSR_PREAMBLE: cfg_ff.preamble_units <= csr_data[12:0];
            CSR_END_GAP:  cfg_ff.end_gap_units  <= csr_data[12:0];
            default: ;
         endcase
      end
   end

   // The front part updates its decoder state as each item is accepted and
   // posts one task per item; the task queue lets it run ahead of the back.
   assign req_accept = req_push && !req_full;

   irkt_front #(.HALF_BIT_LIMIT(HALF_BIT_LIMIT)) u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .accept   (req_accept),
      .req      (req_data),
      .task_out (front_task)
   );

   irkt_fifo #(.WIDTH($bits(task_type)), .DEPTH(TASK_DEPTH)) u_task_q (
      .clock (clock),
      .reset (reset),
      .push  (req_accept),
      .wdata (front_task),
      .pop   (task_pop),
      .rdata (back_task_bits),
      .full  (req_full),
      .empty (task_empty)
   );

   assign back_task = task_type'(back_task_bits);

   // The back part resolves keys for one task at a time and emits at most one
   // event per cycle.
   irkt_back #(.KEY_COUNT(KEY_COUNT)) u_back (
      .clock         (clock),
      .reset         (reset),
      .release_ticks (cfg_ff.release_ticks),
      .task_in       (back_task),
      .task_empty    (task_empty),
      .task_pop      (task_pop),
      .out_full      (out_full),
      .out_push      (out_push),
      .out_item      (out_item)
   );

   // The result queue decouples the consumer from the back part.
   irkt_fifo #(.WIDTH($bits(rsp_type)), .DEPTH(RSP_DEPTH)) u_rsp_q (
      .clock (clock),
      .reset (reset),
      .push  (out_push),
      .wdata (out_item),
      .pop   (rsp_pop),
      .rdata (rsp_bits),
      .full  (out_full),
      .empty (rsp_empty)
   );

   assign rsp_data = rsp_type'(rsp_bits);

endmodule
